// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on a clock, disabled during reset.
`define IIBS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Same, but also checked during reset.
`define IIBS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// File: rtl/iibs_pkg.sv
// Package of the integral image block sum unit: sizes, codes, types.
// Depends on nothing.
package iibs_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 4;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CH_W   = $clog2(MAX_CHANNELS);
    localparam int ADDR_W = ROW_W + COL_W + CH_W;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;

    localparam int SUM_W  = 24;
    localparam int SQ_W   = 32;
    localparam int RUN_W  = 16;
    localparam int RUNQ_W = 24;
    localparam int WORD_W = SUM_W + SQ_W;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_RANGE      = 2'd1;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

    localparam logic [1:0] CORNER_D = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;
    localparam logic [1:0] CORNER_A = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q_RD,
        ST_Q_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [8:0] img_width;
        logic [8:0] img_height;
        logic [2:0] chan_count;
        logic       restart;
    } cfg_t;

endpackage

// File: rtl/iibs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module iibs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/iibs_cfg.sv
// Configuration register bank with saturation of written values.
// Depends on iibs_pkg.
module iibs_cfg import iibs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    output cfg_t       cfg
);
    logic [8:0] width_reg, height_reg;
    logic [2:0] count_reg;
    logic [8:0] sat_dim;
    logic [2:0] sat_cnt;

    always_comb begin
        sat_dim = cfg_data;
        if (cfg_data == 9'd0) begin
            sat_dim = 9'd1;
        end else if (cfg_data > 9'(MAX_WIDTH)) begin
            sat_dim = 9'(MAX_WIDTH);
        end
        sat_cnt = cfg_data[2:0];
        if (cfg_data[2:0] < 3'd3) begin
            sat_cnt = 3'd3;
        end else if (cfg_data[2:0] > 3'(MAX_CHANNELS)) begin
            sat_cnt = 3'(MAX_CHANNELS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'(MAX_WIDTH);
            height_reg <= 9'(MAX_HEIGHT);
            count_reg  <= 3'd3;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= sat_dim;
                REG_IMAGE_HEIGHT:  height_reg <= sat_dim;
                REG_CHANNEL_COUNT: count_reg  <= sat_cnt;
                default: ;
            endcase
        end
    end

    assign cfg.img_width  = width_reg;
    assign cfg.img_height = height_reg;
    assign cfg.chan_count = count_reg;
    assign cfg.restart    = cfg_we && (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
                                                         REG_CHANNEL_COUNT});
endmodule

// File: rtl/integral_image_block_sum.sv
// Integral image block sum unit: builds per-channel summed-area tables of
// values and squares, and answers rectangle sum queries. Uses iibs_pkg,
// iibs_cfg and iibs_ram.
//
// A pixel load works through each channel in turn: the channel reads the
// entry above it from the table RAM, and once the registered read data
// arrives it writes its new entry. A query reads the four corners, each a
// read step and an accumulate step, then posts the result; a query that
// returns an error status posts it without any reads. A result waits in an
// output register, and a load posts none. The next request is accepted
// once a query has placed its result there, which it does only when the
// register is free. The table contents are undefined after reset: no
// clearing pass, a query before a full frame returns status 2. A write to
// any of the three configuration registers restarts the frame at row 0, column 0.
module integral_image_block_sum import iibs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_red_value,
    input  logic [7:0]  s_green_value,
    input  logic [7:0]  s_blue_value,
    input  logic [7:0]  s_alpha_value,
    input  logic [7:0]  s_rect_left,
    input  logic [7:0]  s_rect_top,
    input  logic [8:0]  s_rect_width,
    input  logic [8:0]  s_rect_height,
    input  logic [1:0]  s_query_channel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_block_sum,
    output logic [31:0] m_block_square_sum,
    output logic [1:0]  m_status
);
    cfg_t cfg;

    iibs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Table RAM: each word holds {sum entry, square entry}.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    iibs_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    state_t state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              fc_reg, fc_next;
    logic              first_reg, first_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [RUN_W-1:0]  run_sum_reg [MAX_CHANNELS];
    logic [RUN_W-1:0]  run_sum_next [MAX_CHANNELS];
    logic [RUNQ_W-1:0] run_sq_reg [MAX_CHANNELS];
    logic [RUNQ_W-1:0] run_sq_next [MAX_CHANNELS];
    logic [7:0]        pix_reg [MAX_CHANNELS];
    logic [7:0]        pix_next [MAX_CHANNELS];

    logic [7:0]  x_reg, x_next, y_reg, y_next, x1_reg, x1_next, y1_reg, y1_next;
    logic [CH_W-1:0] qch_reg, qch_next;
    logic [1:0]  corner_reg, corner_next;
    logic [SUM_W-1:0] acc_sum_reg, acc_sum_next;
    logic [SQ_W-1:0]  acc_sq_reg, acc_sq_next;
    logic [1:0]  stat_reg, stat_next;

    logic        m_valid_reg, m_valid_next;
    logic [SUM_W-1:0] m_sum_reg, m_sum_next;
    logic [SQ_W-1:0]  m_sq_reg, m_sq_next;
    logic [1:0]  m_stat_reg, m_stat_next;

    // Scratch values for the load and query paths.
    logic [7:0]        v;
    logic [15:0]       v_sq;
    logic [RUN_W-1:0]  rs;
    logic [RUNQ_W-1:0] rq;
    logic [SUM_W-1:0]  above_s;
    logic [SQ_W-1:0]   above_q;
    logic [9:0]        x_end, y_end;
    logic              bad_rect;
    logic              use_corner, add_corner;
    logic [7:0]        cx, cy;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        fc_next     = fc_reg;
        first_next  = first_reg;
        ch_next     = ch_reg;
        run_sum_next = run_sum_reg;
        run_sq_next  = run_sq_reg;
        pix_next    = pix_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        x1_next     = x1_reg;
        y1_next     = y1_reg;
        qch_next    = qch_reg;
        corner_next = corner_reg;
        acc_sum_next = acc_sum_reg;
        acc_sq_next  = acc_sq_reg;
        stat_next   = stat_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_sum_next  = m_sum_reg;
        m_sq_next   = m_sq_reg;
        m_stat_next = m_stat_reg;

        ram_we    = 1'b0;
        ram_waddr = {row_reg, col_reg, ch_reg};
        ram_wdata = '0;
        ram_raddr = {row_reg - ROW_W'(1), col_reg, ch_reg};

        v       = pix_reg[ch_reg];
        v_sq    = 16'(v) * 16'(v);
        rs      = (first_reg ? '0 : run_sum_reg[ch_reg]) + RUN_W'(v);
        rq      = (first_reg ? '0 : run_sq_reg[ch_reg]) + RUNQ_W'(v_sq);
        above_s = (row_reg != '0) ? ram_rdata[WORD_W-1:SQ_W] : '0;
        above_q = (row_reg != '0) ? ram_rdata[SQ_W-1:0] : '0;

        x_end    = 10'(s_rect_left) + 10'(s_rect_width);
        y_end    = 10'(s_rect_top) + 10'(s_rect_height);
        bad_rect = (s_rect_width == '0) || (s_rect_height == '0)
                || (x_end > 10'(cfg.img_width)) || (y_end > 10'(cfg.img_height))
                || (3'(s_query_channel) >= cfg.chan_count);

        // Corner selection: D and A add, B and C subtract; skip corners
        // that fall on row -1 or column -1.
        cx = x1_reg;
        cy = y1_reg;
        use_corner = 1'b1;
        add_corner = 1'b1;
        case (corner_reg)
            CORNER_D: begin
                cx = x1_reg; cy = y1_reg;
            end
            CORNER_B: begin
                cx = x1_reg; cy = y_reg - 8'd1;
                use_corner = (y_reg != '0); add_corner = 1'b0;
            end
            CORNER_C: begin
                cx = x_reg - 8'd1; cy = y1_reg;
                use_corner = (x_reg != '0); add_corner = 1'b0;
            end
            default: begin
                cx = x_reg - 8'd1; cy = y_reg - 8'd1;
                use_corner = (x_reg != '0) && (y_reg != '0);
            end
        endcase

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_LOAD) begin
                        // Start a new frame after a full one.
                        if (fc_reg) begin
                            col_next = '0;
                            row_next = '0;
                            fc_next  = 1'b0;
                        end
                        first_next  = fc_reg || (col_reg == '0);
                        ch_next     = '0;
                        pix_next[0] = s_red_value;
                        pix_next[1] = s_green_value;
                        pix_next[2] = s_blue_value;
                        pix_next[3] = s_alpha_value;
                        state_next  = ST_LD_RD;
                    end else begin
                        acc_sum_next = '0;
                        acc_sq_next  = '0;
                        x_next      = s_rect_left;
                        y_next      = s_rect_top;
                        x1_next     = 8'(x_end - 10'd1);
                        y1_next     = 8'(y_end - 10'd1);
                        qch_next    = s_query_channel;
                        corner_next = CORNER_D;
                        if (!fc_reg) begin
                            stat_next  = STATUS_INCOMPLETE;
                            state_next = ST_DONE;
                        end else if (bad_rect) begin
                            stat_next  = STATUS_RANGE;
                            state_next = ST_DONE;
                        end else begin
                            stat_next  = STATUS_OK;
                            state_next = ST_Q_RD;
                        end
                    end
                end
            end
            ST_LD_RD: begin
                // Fetch the entry above; its data lands next cycle.
                state_next = ST_LD_WR;
            end
            ST_LD_WR: begin
                ram_we    = 1'b1;
                ram_wdata = {SUM_W'(rs) + above_s, SQ_W'(rq) + above_q};
                run_sum_next[ch_reg] = rs;
                run_sq_next[ch_reg]  = rq;
                if (3'(ch_reg) == cfg.chan_count - 3'd1) begin
                    // Advance the raster position.
                    if (9'(col_reg) + 9'd1 >= cfg.img_width) begin
                        col_next = '0;
                        if (9'(row_reg) + 9'd1 >= cfg.img_height) begin
                            row_next = '0;
                            fc_next  = 1'b1;
                        end else begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end else begin
                        col_next = col_reg + COL_W'(1);
                    end
                    state_next = ST_IDLE;
                end else begin
                    ch_next    = ch_reg + CH_W'(1);
                    state_next = ST_LD_RD;
                end
            end
            ST_Q_RD: begin
                ram_raddr  = {cy, cx, qch_reg};
                state_next = ST_Q_ACC;
            end
            ST_Q_ACC: begin
                if (use_corner) begin
                    if (add_corner) begin
                        acc_sum_next = acc_sum_reg + ram_rdata[WORD_W-1:SQ_W];
                        acc_sq_next  = acc_sq_reg + ram_rdata[SQ_W-1:0];
                    end else begin
                        acc_sum_next = acc_sum_reg - ram_rdata[WORD_W-1:SQ_W];
                        acc_sq_next  = acc_sq_reg - ram_rdata[SQ_W-1:0];
                    end
                end
                if (corner_reg == CORNER_A) begin
                    state_next = ST_DONE;
                end else begin
                    corner_next = corner_reg + 2'd1;
                    state_next  = ST_Q_RD;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = acc_sum_reg;
                    m_sq_next    = acc_sq_reg;
                    m_stat_next  = stat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Writes to the configuration registers restart loading.
        if (cfg.restart) begin
            col_next = '0;
            row_next = '0;
            fc_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            fc_reg      <= 1'b0;
            first_reg   <= 1'b1;
            ch_reg      <= '0;
            corner_reg  <= CORNER_D;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                run_sum_reg[i] <= '0;
                run_sq_reg[i]  <= '0;
            end
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            fc_reg      <= fc_next;
            first_reg   <= first_next;
            ch_reg      <= ch_next;
            corner_reg  <= corner_next;
            m_valid_reg <= m_valid_next;
            run_sum_reg <= run_sum_next;
            run_sq_reg  <= run_sq_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg     <= pix_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        qch_reg     <= qch_next;
        acc_sum_reg <= acc_sum_next;
        acc_sq_reg  <= acc_sq_next;
        stat_reg    <= stat_next;
        m_sum_reg   <= m_sum_next;
        m_sq_reg    <= m_sq_next;
        m_stat_reg  <= m_stat_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_block_sum        = m_sum_reg;
    assign m_block_square_sum = m_sq_reg;
    assign m_status           = m_stat_reg;
endmodule

// File: rtl/iibs_checker.sv
// Port-level checker for integral_image_block_sum, bound to the top level.
// Depends on iibs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iibs_checker import iibs_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_action,
    input logic        m_valid,
    input logic        m_ready,
    input logic [23:0] m_block_sum,
    input logic [31:0] m_block_square_sum,
    input logic [1:0]  m_status
);
    `IIBS_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable({m_block_sum, m_block_square_sum, m_status}))
    `IIBS_ASSERT(a_err_zero, aclk, aresetn, m_valid && m_status != STATUS_OK |-> m_block_sum == '0 && m_block_square_sum == '0)
    `IIBS_ASSERT(a_status_code, aclk, aresetn, m_valid |-> m_status <= STATUS_INCOMPLETE)
    `IIBS_ASSERT(a_load_no_result, aclk, aresetn, s_valid && s_ready && s_action == ACT_LOAD && !m_valid |=> !m_valid)
endmodule

bind integral_image_block_sum iibs_checker u_iibs_checker (.*);
